[rtl/rv32_pkg.sv]
`default_nettype none
package rv32_pkg;

	localparam int REGISTER_COUNT = 32;
	localparam logic [31:0] MISA_VALUE = 32'h4000_1100;
	localparam logic [31:0] SP_RESET = 32'h0000_5a80;
	localparam logic [31:0] ALIGN_MASK = 32'hffff_fffc;
	localparam logic [11:0] MRET_CODE = 12'h302;
	localparam int MIE_BIT = 3;

	localparam logic [1:0] OPN_EXEC = 2'd0;
	localparam logic [1:0] OPN_LOAD = 2'd1;
	localparam logic [1:0] OPN_TIMER = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDEF = 2'd1;
	localparam logic [1:0] ST_EBREAK = 2'd2;

	localparam logic [6:0] OP_REG = 7'h33;
	localparam logic [6:0] OP_IMM = 7'h13;
	localparam logic [6:0] OP_LOADI = 7'h03;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL = 7'h6f;
	localparam logic [6:0] OP_JALR = 7'h67;
	localparam logic [6:0] OP_LUI = 7'h37;
	localparam logic [6:0] OP_AUIPC = 7'h17;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/rv32_ram.sv]
`default_nettype none
module rv32_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/rv32_mdu.sv]
`default_nettype none
module rv32_mdu (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] funct3,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic done,
	output logic [31:0] result
);
	logic is_div_q, neg_q, want_hi_q, rem_q, zero_q, active_q, done_q;
	logic [5:0] cnt_q;
	logic [63:0] acc_q;
	logic [31:0] dvs_q;
	logic [31:0] quo_q;
	logic [32:0] rem_acc_q;
	logic a_s, b_s;
	logic [31:0] a_abs, b_abs;
	logic [32:0] trial;
	logic [63:0] mres;

	always_comb begin
		a_s = (funct3 == 3'd1 || funct3 == 3'd2 || funct3 == 3'd4 || funct3 == 3'd6) && a[31];
		b_s = (funct3 == 3'd1 || funct3 == 3'd4 || funct3 == 3'd6) && b[31];
		a_abs = a_s ? -a : a;
		b_abs = b_s ? -b : b;
		trial = {rem_acc_q[31:0], quo_q[31]} - {1'b0, dvs_q};
		mres = neg_q ? -acc_q : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
			end else if (active_q && cnt_q == 6'd0) begin
				active_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			is_div_q <= funct3[2];
			want_hi_q <= funct3[1:0] != 2'd0;
			rem_q <= funct3[1];
			zero_q <= b == 32'd0;
			neg_q <= funct3[2] ? (funct3[1] ? a_s : (a_s ^ b_s)) : (a_s ^ b_s);
			cnt_q <= 6'd31;
			acc_q <= 64'd0;
			dvs_q <= b_abs;
			quo_q <= a_abs;
			rem_acc_q <= 33'd0;
		end else if (active_q) begin
			if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
			if (is_div_q) begin
				if (!trial[32]) begin
					rem_acc_q <= trial;
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_acc_q <= {rem_acc_q[31:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= {acc_q[62:0], 1'b0} + (quo_q[31] ? {32'd0, dvs_q} : 64'd0);
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q && is_div_q) result = 32'd0;
		else if (is_div_q && rem_q) result = neg_q ? -rem_acc_q[31:0] : rem_acc_q[31:0];
		else if (is_div_q) result = neg_q ? -quo_q : quo_q;
		else if (want_hi_q) result = mres[63:32];
		else result = mres[31:0];
	end

	assign done = done_q;
endmodule
`default_nettype wire

[rtl/rv32im_core_step.sv]
`default_nettype none
// one item per handshake; alu, branch, csr and other exec items pass the read, exec and
// done states; load data, timer and ignored items pass read and done; mul and div items
// also wait in the mul state on the shared radix-2 unit and write back in the div state
// next item accepted once the result register is taken
// arst_n clears pc, csrs, pending load; register file written to reset
// values by a clearing pass over every register after reset, no item accepted meanwhile
module rv32im_core_step #(
	parameter int REGISTER_COUNT = rv32_pkg::REGISTER_COUNT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] operation,
	input wire logic [31:0] instruction,
	input wire logic [31:0] load_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] next_pc,
	output logic mem_read,
	output logic mem_write,
	output logic [31:0] mem_address,
	output logic [3:0] byte_enable,
	output logic [31:0] write_data,
	output logic [1:0] status
);
	localparam int RW = $clog2(REGISTER_COUNT);

	rv32_pkg::state_t state_q, state_d;
	logic clr_q;
	logic [RW-1:0] clr_idx_q;
	logic [1:0] opn_q;
	logic [31:0] ins_q, ld_q, pc_q, a_q;
	logic [31:0] mstatus_q, mie_q, mtvec_q, mstatush_q, mscratch_q, mepc_q, mcause_q;
	logic [31:0] mtval_q, mip_q;
	logic pl_flag_q;
	logic [4:0] pl_dest_q;
	logic [2:0] pl_kind_q;
	logic [1:0] pl_off_q;

	logic rf_we;
	logic [RW-1:0] rf_waddr, rf_raddr;
	logic [31:0] rf_wdata, rf_rdata;

	logic mdu_start, mdu_done;
	logic [31:0] mdu_result;

	logic [6:0] op;
	logic [4:0] rd, rs1, rs2;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [11:0] ir;
	logic [31:0] iimm, simm, bimm, jimm, a, b;

	logic wr_en;
	logic [4:0] wr_rd;
	logic [31:0] wr_val, npc, addr, csr_old, csr_new, src, ldv;
	logic [1:0] st;
	logic mr, mw, csr_wr, is_md, set_pl, taken, alu_ok;
	logic [31:0] maddr, wdat;
	logic [3:0] be;
	logic [4:0] sh;

	rv32_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	rv32_mdu u_mdu (
		.clk(clk), .arst_n(arst_n), .start(mdu_start), .funct3(f3), .a(a_q), .b(rf_rdata),
		.done(mdu_done), .result(mdu_result)
	);

	assign op = ins_q[6:0];
	assign rd = ins_q[11:7];
	assign f3 = ins_q[14:12];
	assign rs1 = ins_q[19:15];
	assign rs2 = ins_q[24:20];
	assign f7 = ins_q[31:25];
	assign ir = ins_q[31:20];
	assign iimm = {{20{ins_q[31]}}, ins_q[31:20]};
	assign simm = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign bimm = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign jimm = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
	assign a = a_q;
	assign b = rf_rdata;
	assign is_md = op == rv32_pkg::OP_REG && f7 == 7'h01;

	always_comb begin
		unique case (ir)
			12'h300: csr_old = mstatus_q;
			12'h301: csr_old = rv32_pkg::MISA_VALUE;
			12'h304: csr_old = mie_q;
			12'h305: csr_old = mtvec_q;
			12'h310: csr_old = mstatush_q;
			12'h340: csr_old = mscratch_q;
			12'h341: csr_old = mepc_q;
			12'h342: csr_old = mcause_q;
			12'h343: csr_old = mtval_q;
			12'h344: csr_old = mip_q;
			default: csr_old = 32'd0;
		endcase
		src = f3[2] ? {27'd0, rs1} : a;
		unique case (f3[1:0])
			2'd1: csr_new = src;
			2'd2: csr_new = csr_old | src;
			default: csr_new = csr_old & ~src;
		endcase
	end

	always_comb begin
		sh = {pl_off_q, 3'b000};
		unique case (pl_kind_q)
			3'd0: begin
				ldv = ld_q >> sh;
				ldv = {{24{ldv[7]}}, ldv[7:0]};
			end
			3'd1: begin
				ldv = ld_q >> {pl_off_q[1], 4'b0000};
				ldv = {{16{ldv[15]}}, ldv[15:0]};
			end
			3'd4: begin
				ldv = ld_q >> sh;
				ldv = {24'd0, ldv[7:0]};
			end
			3'd5: begin
				ldv = ld_q >> {pl_off_q[1], 4'b0000};
				ldv = {16'd0, ldv[15:0]};
			end
			default: ldv = ld_q;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_rd = rd;
		wr_val = 32'd0;
		npc = pc_q + 32'd4;
		st = rv32_pkg::ST_UNDEF;
		mr = 1'b0;
		mw = 1'b0;
		maddr = 32'd0;
		be = 4'd0;
		wdat = 32'd0;
		csr_wr = 1'b0;
		set_pl = 1'b0;
		taken = 1'b0;
		alu_ok = 1'b1;
		addr = a + iimm;
		unique case (op)
			rv32_pkg::OP_REG: begin
				if (f7 == 7'h01) begin
					wr_val = mdu_result;
				end else if (f7 == 7'h20) begin
					if (f3 == 3'd0) wr_val = a - b;
					else if (f3 == 3'd5) wr_val = $signed(a) >>> b[4:0];
					else alu_ok = 1'b0;
				end else if (f7 == 7'h00) begin
					unique case (f3)
						3'd0: wr_val = a + b;
						3'd1: wr_val = a << b[4:0];
						3'd2: wr_val = {31'd0, $signed(a) < $signed(b)};
						3'd3: wr_val = {31'd0, a < b};
						3'd4: wr_val = a ^ b;
						3'd5: wr_val = a >> b[4:0];
						3'd6: wr_val = a | b;
						default: wr_val = a & b;
					endcase
				end else begin
					alu_ok = 1'b0;
				end
				if (alu_ok) begin
					wr_en = 1'b1;
					st = rv32_pkg::ST_OK;
				end
			end
			rv32_pkg::OP_IMM: begin
				st = rv32_pkg::ST_OK;
				wr_en = 1'b1;
				unique case (f3)
					3'd0: wr_val = a + iimm;
					3'd1: wr_val = a << ir[4:0];
					3'd2: wr_val = {31'd0, $signed(a) < $signed(iimm)};
					3'd3: wr_val = {31'd0, a < {20'd0, ir}};
					3'd4: wr_val = a ^ iimm;
					3'd5: wr_val = (ir[11:5] != 7'd0) ? $unsigned($signed(a) >>> ir[4:0])
						: a >> ir[4:0];
					3'd6: wr_val = a | iimm;
					default: wr_val = a & iimm;
				endcase
			end
			rv32_pkg::OP_LOADI: begin
				if (!(f3 == 3'd3 || f3 > 3'd5)) begin
					st = rv32_pkg::ST_OK;
					if (rd != 5'd0) begin
						set_pl = 1'b1;
						mr = 1'b1;
						maddr = (f3 == 3'd2) ? addr : (addr & rv32_pkg::ALIGN_MASK);
					end
				end
			end
			rv32_pkg::OP_STORE: begin
				addr = a + simm;
				st = rv32_pkg::ST_OK;
				if (f3 == 3'd0) begin
					be = 4'd1 << addr[1:0];
					wdat = {24'd0, b[7:0]} << {addr[1:0], 3'b000};
					maddr = addr & rv32_pkg::ALIGN_MASK;
					mw = 1'b1;
				end else if (f3 == 3'd1) begin
					be = addr[1] ? 4'hc : 4'h3;
					wdat = {16'd0, b[15:0]} << {addr[1], 4'b0000};
					maddr = addr & rv32_pkg::ALIGN_MASK;
					mw = 1'b1;
				end else if (f3 == 3'd2) begin
					be = 4'hf;
					wdat = b;
					maddr = addr;
					mw = 1'b1;
				end else begin
					st = rv32_pkg::ST_UNDEF;
				end
			end
			rv32_pkg::OP_BRANCH: begin
				st = rv32_pkg::ST_OK;
				unique case (f3)
					3'd0: taken = a == b;
					3'd1: taken = a != b;
					3'd4: taken = $signed(a) < $signed(b);
					3'd5: taken = $signed(a) >= $signed(b);
					3'd6: taken = a < b;
					3'd7: taken = a >= b;
					default: st = rv32_pkg::ST_UNDEF;
				endcase
				if (taken) npc = pc_q + bimm;
			end
			rv32_pkg::OP_JAL: begin
				wr_en = 1'b1;
				wr_val = pc_q + 32'd4;
				npc = pc_q + jimm;
				st = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_JALR: begin
				if (f3 == 3'd0) begin
					wr_en = 1'b1;
					wr_val = pc_q + 32'd4;
					npc = addr & 32'hffff_fffe;
					st = rv32_pkg::ST_OK;
				end
			end
			rv32_pkg::OP_LUI: begin
				wr_en = 1'b1;
				wr_val = {ins_q[31:12], 12'd0};
				st = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_AUIPC: begin
				wr_en = 1'b1;
				wr_val = pc_q + {ins_q[31:12], 12'd0};
				st = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_SYSTEM: begin
				if (f3 == 3'd0) begin
					if (ir == 12'd0) begin
						npc = mtvec_q & rv32_pkg::ALIGN_MASK;
						st = rv32_pkg::ST_OK;
					end else if (ir == 12'd1) begin
						st = rv32_pkg::ST_EBREAK;
					end else if (ir == rv32_pkg::MRET_CODE) begin
						npc = mepc_q;
						st = rv32_pkg::ST_OK;
					end
				end else if (f3 != 3'd4) begin
					wr_en = 1'b1;
					wr_val = csr_old;
					csr_wr = 1'b1;
					st = rv32_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		mdu_start = 1'b0;
		rf_we = 1'b0;
		rf_waddr = clr_idx_q;
		rf_wdata = (clr_idx_q == RW'(2)) ? rv32_pkg::SP_RESET : 32'd0;
		rf_raddr = rs1;
		unique case (state_q)
			rv32_pkg::S_IDLE: begin
				rf_raddr = RW'(instruction[19:15]);
				if (clr_q) begin
					rf_we = 1'b1;
				end else if (!out_valid || !out_stall) begin
					in_stall = 1'b0;
					if (in_valid) state_d = rv32_pkg::S_READ;
				end
			end
			rv32_pkg::S_READ: begin
				rf_raddr = rs2;
				if (opn_q == rv32_pkg::OPN_EXEC) begin
					state_d = rv32_pkg::S_EXEC;
				end else begin
					if (opn_q == rv32_pkg::OPN_LOAD && pl_flag_q && pl_dest_q != 5'd0) begin
						rf_we = 1'b1;
						rf_waddr = RW'(pl_dest_q);
						rf_wdata = ldv;
					end
					state_d = rv32_pkg::S_DONE;
				end
			end
			rv32_pkg::S_EXEC: begin
				rf_raddr = rs2;
				if (is_md) begin
					mdu_start = 1'b1;
					state_d = rv32_pkg::S_MUL;
				end else begin
					rf_we = wr_en && rd != 5'd0;
					rf_waddr = RW'(wr_rd);
					rf_wdata = wr_val;
					state_d = rv32_pkg::S_DONE;
				end
			end
			rv32_pkg::S_MUL: begin
				rf_raddr = rs2;
				if (mdu_done) state_d = rv32_pkg::S_DIV;
			end
			rv32_pkg::S_DIV: begin
				rf_raddr = rs2;
				rf_we = rd != 5'd0;
				rf_waddr = RW'(rd);
				rf_wdata = mdu_result;
				state_d = rv32_pkg::S_DONE;
			end
			rv32_pkg::S_DONE: state_d = rv32_pkg::S_IDLE;
			default: state_d = rv32_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rv32_pkg::S_IDLE;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			out_valid <= 1'b0;
			pc_q <= 32'd0;
			mstatus_q <= 32'd0;
			mie_q <= 32'd0;
			mtvec_q <= 32'd0;
			mstatush_q <= 32'd0;
			mscratch_q <= 32'd0;
			mepc_q <= 32'd0;
			mcause_q <= 32'd0;
			mtval_q <= 32'd0;
			mip_q <= 32'd0;
			pl_flag_q <= 1'b0;
			pl_dest_q <= 5'd0;
			pl_kind_q <= 3'd0;
			pl_off_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + RW'(1);
				if (clr_idx_q == RW'(REGISTER_COUNT - 1)) clr_q <= 1'b0;
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == rv32_pkg::S_READ && opn_q != rv32_pkg::OPN_EXEC) begin
				if (opn_q == rv32_pkg::OPN_LOAD) pl_flag_q <= 1'b0;
				if (opn_q == rv32_pkg::OPN_TIMER && mstatus_q[rv32_pkg::MIE_BIT]) begin
					mepc_q <= pc_q;
					pc_q <= mtvec_q & rv32_pkg::ALIGN_MASK;
				end
			end
			if ((state_q == rv32_pkg::S_EXEC && !is_md) || state_q == rv32_pkg::S_DIV) begin
				pc_q <= npc;
				pl_flag_q <= set_pl;
				if (set_pl) begin
					pl_dest_q <= rd;
					pl_kind_q <= f3;
					pl_off_q <= addr[1:0];
				end
				if (op == rv32_pkg::OP_SYSTEM && f3 == 3'd0 && ir == 12'd0) begin
					mepc_q <= pc_q;
					mcause_q <= 32'd11;
				end
				if (csr_wr) begin
					unique case (ir)
						12'h300: mstatus_q <= csr_new;
						12'h304: mie_q <= csr_new;
						12'h305: mtvec_q <= csr_new & rv32_pkg::ALIGN_MASK;
						12'h310: mstatush_q <= csr_new;
						12'h340: mscratch_q <= csr_new;
						12'h341: mepc_q <= csr_new;
						12'h342: mcause_q <= csr_new;
						12'h343: mtval_q <= csr_new;
						12'h344: mip_q <= csr_new;
						default: ;
					endcase
				end
			end
			if (state_q == rv32_pkg::S_DONE) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rv32_pkg::S_IDLE && !in_stall && in_valid) begin
			opn_q <= operation;
			ins_q <= instruction;
			ld_q <= load_data;
		end
		if (state_q == rv32_pkg::S_READ) a_q <= rf_rdata;
		if (state_q == rv32_pkg::S_READ && opn_q != rv32_pkg::OPN_EXEC) begin
			mem_read <= 1'b0;
			mem_write <= 1'b0;
			mem_address <= 32'd0;
			byte_enable <= 4'd0;
			write_data <= 32'd0;
			status <= rv32_pkg::ST_OK;
		end
		if ((state_q == rv32_pkg::S_EXEC && !is_md) || state_q == rv32_pkg::S_DIV) begin
			mem_read <= mr;
			mem_write <= mw;
			mem_address <= maddr;
			byte_enable <= be;
			write_data <= wdat;
			status <= st;
		end
	end

	assign next_pc = pc_q;
endmodule
`default_nettype wire

[rtl/rv32_checker.sv]
`default_nettype none
module rv32_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic mem_read,
	input wire logic mem_write,
	input wire logic [3:0] byte_enable,
	input wire logic [1:0] status
);
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mem_read && mem_write)) else $error("read and write together");
	a_be_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mem_write) |-> byte_enable == 4'd0) else $error("lanes without store");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("item taken while busy");
endmodule

bind rv32im_core_step rv32_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .mem_read(mem_read),
	.mem_write(mem_write), .byte_enable(byte_enable), .status(status)
);
`default_nettype wire

[tb/rv32im_core_step_tb.sv]
`default_nettype none
module rv32im_core_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] operation;
		logic [31:0] instruction;
		logic [31:0] load_data;
	} step_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic mem_read;
		logic mem_write;
		logic [31:0] mem_address;
		logic [3:0] byte_enable;
		logic [31:0] write_data;
		logic [1:0] status;
	} core_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [31:0] instruction = '0;
	logic [31:0] load_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] next_pc;
	logic mem_read;
	logic mem_write;
	logic [31:0] mem_address;
	logic [3:0] byte_enable;
	logic [31:0] write_data;
	logic [1:0] status;

	rv32im_core_step dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .instruction(instruction), .load_data(load_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .mem_read(mem_read), .mem_write(mem_write),
		.mem_address(mem_address), .byte_enable(byte_enable),
		.write_data(write_data), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	step_item_t pending_items[$];
	core_result_t expected_results[$];
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	bit hold_sender = 1'b0;
	bit in_taken = 1'b0;
	int mismatch_count = 0;
	int accepted_count = 0;

	// shadow architectural state
	logic [31:0] gpr [32];
	logic [31:0] pc_q;
	logic [31:0] csr_mstatus, csr_mie, csr_mtvec, csr_mstatush, csr_mscratch;
	logic [31:0] csr_mepc, csr_mcause, csr_mtval, csr_mip;
	logic load_wait;
	logic [4:0] load_rd;
	logic [2:0] load_kind;
	logic [1:0] load_ofs;

	task automatic reset_shadow();
		foreach (gpr[i]) gpr[i] = '0;
		gpr[2] = rv32_pkg::SP_RESET;
		pc_q = '0;
		{csr_mstatus, csr_mie, csr_mtvec, csr_mstatush, csr_mscratch} = '0;
		{csr_mepc, csr_mcause, csr_mtval, csr_mip} = '0;
		load_wait = 1'b0;
		load_rd = '0;
		load_kind = '0;
		load_ofs = '0;
	endtask

	function automatic void set_gpr(logic [4:0] r, logic [31:0] v);
		if (r != 0) gpr[r] = v;
	endfunction

	function automatic logic [31:0] read_csr(logic [11:0] a);
		case (a)
			12'h300: return csr_mstatus;
			12'h301: return rv32_pkg::MISA_VALUE;
			12'h304: return csr_mie;
			12'h305: return csr_mtvec;
			12'h310: return csr_mstatush;
			12'h340: return csr_mscratch;
			12'h341: return csr_mepc;
			12'h342: return csr_mcause;
			12'h343: return csr_mtval;
			12'h344: return csr_mip;
			default: return '0;
		endcase
	endfunction

	function automatic void write_csr(logic [11:0] a, logic [31:0] v);
		case (a)
			12'h300: csr_mstatus = v;
			12'h304: csr_mie = v;
			12'h305: csr_mtvec = v & rv32_pkg::ALIGN_MASK;
			12'h310: csr_mstatush = v;
			12'h340: csr_mscratch = v;
			12'h341: csr_mepc = v;
			12'h342: csr_mcause = v;
			12'h343: csr_mtval = v;
			12'h344: csr_mip = v;
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] shift_arith(logic [31:0] a, logic [4:0] s);
		return $unsigned($signed(a) >>> s);
	endfunction

	function automatic bit reg_alu(logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
			logic [31:0] b, output logic [31:0] r);
		logic [63:0] prod;
		bit ovf;
		ovf = (a == 32'h8000_0000) && (b == 32'hffff_ffff);
		r = '0;
		if (f7 == 7'h01) begin
			case (f3)
				3'd0: r = a * b;
				3'd1: begin
					prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					r = prod[63:32];
				end
				3'd2: begin
					prod = {{32{a[31]}}, a} * {32'd0, b};
					r = prod[63:32];
				end
				3'd3: begin
					prod = {32'd0, a} * {32'd0, b};
					r = prod[63:32];
				end
				3'd4: r = (b == 0) ? '0 : ovf ? 32'h8000_0000
					: $unsigned($signed(a) / $signed(b));
				3'd5: r = (b == 0) ? '0 : a / b;
				3'd6: r = (b == 0 || ovf) ? '0 : $unsigned($signed(a) % $signed(b));
				default: r = (b == 0) ? '0 : a % b;
			endcase
			return 1;
		end
		if (f7 == 7'h20) begin
			if (f3 == 3'd0) begin
				r = a - b;
				return 1;
			end
			if (f3 == 3'd5) begin
				r = shift_arith(a, b[4:0]);
				return 1;
			end
			return 0;
		end
		if (f7 != 0) return 0;
		case (f3)
			3'd0: r = a + b;
			3'd1: r = a << b[4:0];
			3'd2: r = ($signed(a) < $signed(b)) ? 1 : 0;
			3'd3: r = (a < b) ? 1 : 0;
			3'd4: r = a ^ b;
			3'd5: r = a >> b[4:0];
			3'd6: r = a | b;
			default: r = a & b;
		endcase
		return 1;
	endfunction

	function automatic core_result_t run_instruction(logic [31:0] ins);
		core_result_t res;
		logic [6:0] opc;
		logic [4:0] rd, rs1, rs2;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [31:0] a, b, pc, npc, iimm, simm, bimm, jimm, r, addr, old, src, nv;
		logic [11:0] ir;
		bit taken;
		res = '0;
		opc = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		rs1 = ins[19:15];
		rs2 = ins[24:20];
		f7 = ins[31:25];
		a = gpr[rs1];
		b = gpr[rs2];
		pc = pc_q;
		npc = pc + 4;
		ir = ins[31:20];
		iimm = {{20{ins[31]}}, ins[31:20]};
		simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
		bimm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		jimm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		res.status = rv32_pkg::ST_UNDEF;
		load_wait = 1'b0;
		case (opc)
			rv32_pkg::OP_REG: if (reg_alu(f3, f7, a, b, r)) begin
				set_gpr(rd, r);
				res.status = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_IMM: begin
				res.status = rv32_pkg::ST_OK;
				case (f3)
					3'd0: r = a + iimm;
					3'd1: r = a << ir[4:0];
					3'd2: r = ($signed(a) < $signed(iimm)) ? 1 : 0;
					3'd3: r = (a < {20'd0, ir}) ? 1 : 0;
					3'd4: r = a ^ iimm;
					3'd5: r = (ir[11:5] != 0) ? shift_arith(a, ir[4:0]) : a >> ir[4:0];
					3'd6: r = a | iimm;
					default: r = a & iimm;
				endcase
				set_gpr(rd, r);
			end
			rv32_pkg::OP_LOADI: if (!(f3 == 3'd3 || f3 > 3'd5)) begin
				res.status = rv32_pkg::ST_OK;
				if (rd != 0) begin
					addr = a + iimm;
					load_wait = 1'b1;
					load_rd = rd;
					load_kind = f3;
					load_ofs = addr[1:0];
					res.mem_read = 1'b1;
					res.mem_address = (f3 == 3'd2) ? addr : addr & rv32_pkg::ALIGN_MASK;
				end
			end
			rv32_pkg::OP_STORE: begin
				addr = a + simm;
				if (f3 <= 3'd2) begin
					res.status = rv32_pkg::ST_OK;
					res.mem_write = 1'b1;
					res.mem_address = (f3 == 3'd2) ? addr : addr & rv32_pkg::ALIGN_MASK;
					case (f3)
						3'd0: begin
							res.byte_enable = 4'b0001 << addr[1:0];
							res.write_data = {24'd0, b[7:0]} << (addr[1:0] * 8);
						end
						3'd1: begin
							res.byte_enable = addr[1] ? 4'hc : 4'h3;
							res.write_data = {16'd0, b[15:0]} << (addr[1] * 16);
						end
						default: begin
							res.byte_enable = 4'hf;
							res.write_data = b;
						end
					endcase
				end
			end
			rv32_pkg::OP_BRANCH: begin
				res.status = rv32_pkg::ST_OK;
				taken = 0;
				case (f3)
					3'd0: taken = a == b;
					3'd1: taken = a != b;
					3'd4: taken = $signed(a) < $signed(b);
					3'd5: taken = $signed(a) >= $signed(b);
					3'd6: taken = a < b;
					3'd7: taken = a >= b;
					default: res.status = rv32_pkg::ST_UNDEF;
				endcase
				if (taken) npc = pc + bimm;
			end
			rv32_pkg::OP_JAL: begin
				set_gpr(rd, pc + 4);
				npc = pc + jimm;
				res.status = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_JALR: if (f3 == 0) begin
				set_gpr(rd, pc + 4);
				npc = (a + iimm) & 32'hffff_fffe;
				res.status = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_LUI: begin
				set_gpr(rd, {ins[31:12], 12'd0});
				res.status = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_AUIPC: begin
				set_gpr(rd, pc + {ins[31:12], 12'd0});
				res.status = rv32_pkg::ST_OK;
			end
			rv32_pkg::OP_SYSTEM: if (f3 == 0) begin
				if (ir == 0) begin
					csr_mepc = pc;
					csr_mcause = 32'd11;
					npc = csr_mtvec & rv32_pkg::ALIGN_MASK;
					res.status = rv32_pkg::ST_OK;
				end else if (ir == 1) begin
					res.status = rv32_pkg::ST_EBREAK;
				end else if (ir == rv32_pkg::MRET_CODE) begin
					npc = csr_mepc;
					res.status = rv32_pkg::ST_OK;
				end
			end else if (f3 != 3'd4) begin
				src = f3[2] ? {27'd0, rs1} : a;
				old = read_csr(ir);
				case (f3[1:0])
					2'd1: nv = src;
					2'd2: nv = old | src;
					default: nv = old & ~src;
				endcase
				set_gpr(rd, old);
				write_csr(ir, nv);
				res.status = rv32_pkg::ST_OK;
			end
			default: ;
		endcase
		pc_q = npc;
		res.next_pc = pc_q;
		return res;
	endfunction

	function automatic core_result_t predict_core(step_item_t it);
		core_result_t res;
		logic [31:0] d, v;
		res = '0;
		case (it.operation)
			rv32_pkg::OPN_EXEC: res = run_instruction(it.instruction);
			rv32_pkg::OPN_LOAD: if (load_wait) begin
				d = it.load_data;
				case (load_kind)
					3'd0: v = {{24{d[load_ofs*8+7]}}, d[load_ofs*8 +: 8]};
					3'd1: v = {{16{d[load_ofs[1]*16+15]}}, d[load_ofs[1]*16 +: 16]};
					3'd4: v = {24'd0, d[load_ofs*8 +: 8]};
					3'd5: v = {16'd0, d[load_ofs[1]*16 +: 16]};
					default: v = d;
				endcase
				set_gpr(load_rd, v);
				load_wait = 1'b0;
			end
			rv32_pkg::OPN_TIMER: if (csr_mstatus[rv32_pkg::MIE_BIT]) begin
				csr_mepc = pc_q;
				pc_q = csr_mtvec & rv32_pkg::ALIGN_MASK;
			end
			default: ;
		endcase
		res.next_pc = pc_q;
		return res;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (!hold_sender && pending_items.size() > 0
						&& $urandom_range(99) >= sender_idle_pct) begin
					step_item_t it;
					it = pending_items.pop_front();
					operation <= it.operation;
					instruction <= it.instruction;
					load_data <= it.load_data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_core({operation, instruction, load_data}));
				accepted_count++;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) $display("unexpected result pc=%h", next_pc);
				end else begin
					core_result_t e;
					core_result_t got;
					e = expected_results.pop_front();
					got = {next_pc, mem_read, mem_write, mem_address, byte_enable,
						write_data, status};
					if (got !== e) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected pc=%h rd=%b wr=%b addr=%h be=%h wd=%h st=%0d, actual pc=%h rd=%b wr=%b addr=%h be=%h wd=%h st=%0d",
								e.next_pc, e.mem_read, e.mem_write, e.mem_address,
								e.byte_enable, e.write_data, e.status,
								got.next_pc, got.mem_read, got.mem_write, got.mem_address,
								got.byte_enable, got.write_data, got.status);
					end
				end
			end
		end
	end

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	task automatic push_exec(logic [31:0] ins);
		pending_items.push_back({rv32_pkg::OPN_EXEC, ins, $urandom()});
	endtask

	task automatic push_other(logic [1:0] opn, logic [31:0] d);
		pending_items.push_back({opn, $urandom(), d});
	endtask

	function automatic logic [4:0] rand_reg();
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [11:0] rand_csr();
		logic [11:0] csrs [11] = '{12'h300, 12'h301, 12'h304, 12'h305, 12'h310, 12'h340,
			12'h341, 12'h342, 12'h343, 12'h344, 12'hf14};
		if ($urandom_range(9) == 0) return 12'($urandom());
		return csrs[$urandom_range(10)];
	endfunction

	task automatic push_random();
		int k;
		logic [4:0] rd;
		k = $urandom_range(99);
		rd = rand_reg();
		if (k < 14)
			push_exec(enc_r($urandom_range(3) == 0 ? 7'h01 : ($urandom_range(1) ? 7'h20 : 7'h00),
				rand_reg(), rand_reg(), 3'($urandom()), rd, rv32_pkg::OP_REG));
		else if (k < 20)
			push_exec(enc_r(7'h01, rand_reg(), rand_reg(), 3'($urandom()), rd, rv32_pkg::OP_REG));
		else if (k < 34)
			push_exec(enc_i(12'($urandom()), rand_reg(), 3'($urandom()), rd, rv32_pkg::OP_IMM));
		else if (k < 38)
			push_exec(enc_i(12'($urandom_range(1)), rand_reg(), 3'($urandom_range(7)), rd,
				rv32_pkg::OP_LOADI) | ($urandom() & 32'hfff0_0000));
		else if (k < 50) begin
			push_exec(enc_i(12'($urandom()), rand_reg(), 3'($urandom()), rd,
				rv32_pkg::OP_LOADI));
			if ($urandom_range(9) != 0) push_other(rv32_pkg::OPN_LOAD, $urandom());
		end else if (k < 60)
			push_exec(enc_i(12'($urandom()), rand_reg(), 3'($urandom_range(3)), 5'($urandom()),
				rv32_pkg::OP_STORE));
		else if (k < 68)
			push_exec(enc_i(12'($urandom()), rand_reg(), 3'($urandom()), 5'($urandom()),
				rv32_pkg::OP_BRANCH));
		else if (k < 71)
			push_exec(($urandom() & 32'hffff_f000) | {20'h0, rd, rv32_pkg::OP_JAL});
		else if (k < 74)
			push_exec(enc_i(12'($urandom()), rand_reg(), $urandom_range(7) == 0 ? 3'd1 : 3'd0,
				rd, rv32_pkg::OP_JALR));
		else if (k < 78)
			push_exec(($urandom() & 32'hffff_f000) | {20'h0, rd,
				$urandom_range(1) ? rv32_pkg::OP_LUI : rv32_pkg::OP_AUIPC});
		else if (k < 88)
			push_exec(enc_i(rand_csr(), rand_reg(), 3'($urandom()), rd, rv32_pkg::OP_SYSTEM));
		else if (k < 92) begin
			case ($urandom_range(3))
				0: push_exec(32'h0000_0073);
				1: push_exec(32'h0010_0073);
				2: push_exec(32'h3020_0073);
				default: push_exec(enc_i(12'($urandom()), rand_reg(), 3'd0, rd,
					rv32_pkg::OP_SYSTEM));
			endcase
		end else if (k < 95)
			push_other(rv32_pkg::OPN_TIMER, $urandom());
		else if (k < 97)
			push_other($urandom_range(1) ? 2'd3 : rv32_pkg::OPN_LOAD, $urandom());
		else
			push_exec($urandom());
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		reset_shadow();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		push_exec(enc_i(12'h7ff, 5'd0, 3'd0, 5'd1, rv32_pkg::OP_IMM));
		push_exec(enc_i(12'h800, 5'd0, 3'd0, 5'd3, rv32_pkg::OP_IMM));
		push_exec(32'hffff_f2b7);
		push_exec(enc_r(7'h01, 5'd3, 5'd5, 3'd4, 5'd6, rv32_pkg::OP_REG));
		push_exec(enc_r(7'h01, 5'd0, 5'd5, 3'd6, 5'd7, rv32_pkg::OP_REG));
		push_exec(enc_i(12'hfff, 5'd0, 3'd0, 5'd8, rv32_pkg::OP_IMM));
		push_exec(32'h8000_0237);
		push_exec(enc_r(7'h01, 5'd8, 5'd4, 3'd4, 5'd9, rv32_pkg::OP_REG));
		push_exec(enc_r(7'h20, 5'd1, 5'd3, 3'd5, 5'd10, rv32_pkg::OP_REG));
		push_exec(enc_i(12'h41f, 5'd3, 3'd5, 5'd11, rv32_pkg::OP_IMM));
		push_exec(enc_i(12'h03f, 5'd3, 3'd1, 5'd12, rv32_pkg::OP_IMM));
		push_exec(enc_i(12'h003, 5'd2, 3'd0, 5'd13, rv32_pkg::OP_LOADI));
		push_other(rv32_pkg::OPN_LOAD, 32'h80ff_7f01);
		push_exec(enc_i(12'h002, 5'd2, 3'd5, 5'd0, rv32_pkg::OP_LOADI));
		push_other(rv32_pkg::OPN_LOAD, 32'hffff_ffff);
		push_exec(enc_i(12'h001, 5'd2, 3'd1, 5'd3, rv32_pkg::OP_STORE));
		push_exec(enc_i(12'h105, 5'd2, 3'd1, 5'd0, rv32_pkg::OP_SYSTEM));
		push_exec(enc_i(12'h300, 5'd8, 3'd6, 5'd14, rv32_pkg::OP_SYSTEM));
		push_exec(enc_i(12'h301, 5'd8, 3'd3, 5'd15, rv32_pkg::OP_SYSTEM));
		push_other(rv32_pkg::OPN_TIMER, 32'h0);
		push_exec(32'h0000_0073);
		push_exec(32'h3020_0073);
		push_exec(32'h0010_0073);
		push_exec(enc_i(12'h003, 5'd1, 3'd0, 5'd16, rv32_pkg::OP_JALR));
		push_exec(32'hffff_ffff);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 59 : 0;
			receiver_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 6 : 0;
			for (int n = 0; n < 430; n++) begin
				push_random();
				if (n == 215) begin
					while (pending_items.size() > 0 || in_valid) @(posedge clk);
					hold_sender = 1'b1;
					wait_drained();
					hold_sender = 1'b0;
				end
			end
			while (pending_items.size() > 0) @(posedge clk);
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
